FILE: sv/sensor_sample_report_filter_unit_defines.svh
// Assertion helpers for the sensor sample/report filter.
`ifndef SENSOR_SAMPLE_REPORT_FILTER_UNIT_DEFINES_SVH
`define SENSOR_SAMPLE_REPORT_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SSRF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SSRF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SSRF_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define SSRF_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/ssrf_pkg.sv
package ssrf_pkg;

   localparam int VALUE_W = 24;

   typedef logic [31:0]                stamp_type;
   typedef logic [9:0]                 counts_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [22:0]                step_type;
   typedef logic [15:0]                period_type;
   typedef logic [1:0]                 mode_type;
   typedef logic [2:0]                 reason_type;

   // count range defaults (top-level parameters)
   localparam int COUNT_LOW_DEF  = 0;
   localparam int COUNT_HIGH_DEF = 1023;

   // a new sample needs strictly more than this many seconds
   localparam stamp_type SAMPLE_INTERVAL = 32'd1;

   localparam mode_type MODE_ANALOG     = 2'd0;
   localparam int       MODE_INVERT_BIT = 1;

   localparam reason_type REASON_NONE       = 3'd0;
   localparam reason_type REASON_GT         = 3'd1;
   localparam reason_type REASON_LT         = 3'd2;
   localparam reason_type REASON_STEP       = 3'd3;
   localparam reason_type REASON_HEARTBEAT  = 3'd4;
   localparam reason_type REASON_BIT_CHANGE = 3'd5;

   // CSR map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   typedef logic [CSR_ADDR_W-3:0] reg_index_type;

   localparam reg_index_type REG_SENSOR_MODE     = 3'd0;
   localparam reg_index_type REG_VALUE_MIN       = 3'd1;
   localparam reg_index_type REG_VALUE_MAX       = 3'd2;
   localparam reg_index_type REG_UPPER_THRESHOLD = 3'd3;
   localparam reg_index_type REG_LOWER_THRESHOLD = 3'd4;
   localparam reg_index_type REG_STEP_SIZE       = 3'd5;
   localparam reg_index_type REG_MIN_PERIOD      = 3'd6;
   localparam reg_index_type REG_MAX_PERIOD      = 3'd7;

   localparam mode_type   SENSOR_MODE_RST     = MODE_ANALOG;
   localparam value_type  VALUE_MIN_RST       = 24'sd0;
   localparam value_type  VALUE_MAX_RST       = 24'sd25600;
   localparam value_type  UPPER_THRESHOLD_RST = 24'sd10240;
   localparam value_type  LOWER_THRESHOLD_RST = 24'sd15360;
   localparam step_type   STEP_SIZE_RST       = 23'd256;
   localparam period_type MIN_PERIOD_RST      = 16'd1;
   localparam period_type MAX_PERIOD_RST      = 16'd5;

endpackage

FILE: sv/ssrf_req_if.sv
interface ssrf_req_if import ssrf_pkg::*; ();

   logic       valid;
   logic       ready;
   stamp_type  timestamp;
   counts_type raw_counts;
   logic       raw_bit;

   modport source (output valid, output timestamp, output raw_counts, output raw_bit,
                   input ready);
   modport sink   (input valid, input timestamp, input raw_counts, input raw_bit,
                   output ready);

endinterface

FILE: sv/ssrf_rsp_if.sv
interface ssrf_rsp_if import ssrf_pkg::*; ();

   logic       valid;
   logic       ready;
   logic       sampled;
   logic       report;
   reason_type reason;
   value_type  scaled_value;
   logic       bit_value;

   modport source (output valid, output sampled, output report, output reason,
                   output scaled_value, output bit_value, input ready);
   modport sink   (input valid, input sampled, input report, input reason,
                   input scaled_value, input bit_value, output ready);

endinterface

FILE: sv/sensor_sample_report_filter_unit.sv
// Sensor sample/report filter.
// Pipeline: 7 registers from request accept to result valid.
// Throughput: one request per cycle while results are taken; rsp_chan.ready low stalls
//   the scaling stages (count multiply, reciprocal divide split into partial products, offset add).
// Reset (synchronous, active high): pipeline emptied, CSRs to defaults,
//   held values, reported values and timestamps cleared to zero.
`include "sensor_sample_report_filter_unit_defines.svh"

module sensor_sample_report_filter_unit
   import ssrf_pkg::*;
#(
   parameter int COUNT_LOW  = COUNT_LOW_DEF,
   parameter int COUNT_HIGH = COUNT_HIGH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ssrf_req_if.sink              req_chan,
   ssrf_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ------------------------------------------------------------------
   // Scaling constants. value = vmin + round(c * (vmax - vmin) / SPAN),
   // ties away from zero. The divide by SPAN is an exact reciprocal
   // multiply: for x < 2**MAG_W, floor(x / SPAN) ==
   // (x * RECIP) >> (MAG_W + SPAN_LOG), RECIP = ceil(2**(MAG_W+SPAN_LOG)/SPAN).
   // ------------------------------------------------------------------
   localparam bit SPAN_OK   = COUNT_HIGH > COUNT_LOW;   // empty span -> vmin
   localparam int SPAN      = SPAN_OK ? COUNT_HIGH - COUNT_LOW : 1;
   localparam int SPAN_W    = $clog2(SPAN + 1);
   localparam int SPAN_LOG  = $clog2(SPAN);
   localparam int PROD_W    = SPAN_W + VALUE_W + 2;     // signed c * diff
   localparam int MAG_W     = SPAN_W + VALUE_W;         // |c*diff| + SPAN/2
   localparam int RECIP_W   = MAG_W + 1;
   localparam logic [63:0] RECIP =
      ((64'd1 << (MAG_W + SPAN_LOG)) + 64'(SPAN) - 64'd1) / 64'(SPAN);
   localparam int QUOT_SHIFT = MAG_W + SPAN_LOG;
   localparam int QUOT_W     = VALUE_W + 1;
   localparam int AL_W       = (MAG_W + 1) / 2;
   localparam int AH_W       = MAG_W - AL_W;
   localparam int ML_W       = (RECIP_W + 1) / 2;
   localparam int MH_W       = RECIP_W - ML_W;
   localparam int PR_W       = MAG_W + RECIP_W;
   localparam logic [ML_W-1:0]  RECIP_LO  = RECIP[ML_W-1:0];
   localparam logic [MH_W-1:0]  RECIP_HI  = RECIP[RECIP_W-1:ML_W];
   localparam logic [MAG_W-1:0] HALF_SPAN = MAG_W'(SPAN / 2);

   localparam int CNT_EXT_W = 17;
   localparam logic [CNT_EXT_W-1:0] CNT_LO = CNT_EXT_W'(COUNT_LOW);
   localparam logic [CNT_EXT_W-1:0] CNT_HI = CNT_EXT_W'(COUNT_HIGH);

   localparam int SUM_W = VALUE_W + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (VALUE_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (VALUE_W - 1)));

   localparam int NUM_STAGES = 6;

   // ------------------------------------------------------------------
   // CSRs
   // ------------------------------------------------------------------
   mode_type   sensor_mode_ff;
   value_type  value_min_ff;
   value_type  value_max_ff;
   value_type  upper_threshold_ff;
   value_type  lower_threshold_ff;
   step_type   step_size_ff;
   period_type min_period_ff;
   period_type max_period_ff;

   reg_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_mode_ff     <= SENSOR_MODE_RST;
         value_min_ff       <= VALUE_MIN_RST;
         value_max_ff       <= VALUE_MAX_RST;
         upper_threshold_ff <= UPPER_THRESHOLD_RST;
         lower_threshold_ff <= LOWER_THRESHOLD_RST;
         step_size_ff       <= STEP_SIZE_RST;
         min_period_ff      <= MIN_PERIOD_RST;
         max_period_ff      <= MAX_PERIOD_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SENSOR_MODE:     sensor_mode_ff     <= csr_pwdata[1:0];
            REG_VALUE_MIN:       value_min_ff       <= csr_pwdata[VALUE_W-1:0];
            REG_VALUE_MAX:       value_max_ff       <= csr_pwdata[VALUE_W-1:0];
            REG_UPPER_THRESHOLD: upper_threshold_ff <= csr_pwdata[VALUE_W-1:0];
            REG_LOWER_THRESHOLD: lower_threshold_ff <= csr_pwdata[VALUE_W-1:0];
            REG_STEP_SIZE:       step_size_ff       <= csr_pwdata[22:0];
            REG_MIN_PERIOD:      min_period_ff      <= csr_pwdata[15:0];
            REG_MAX_PERIOD:      max_period_ff      <= csr_pwdata[15:0];
         endcase
      end
   end

   // read data; signed values come back sign extended
   always_comb begin
      unique case (csr_index)
         REG_SENSOR_MODE:     csr_prdata = {30'd0, sensor_mode_ff};
         REG_VALUE_MIN:       csr_prdata = {{8{value_min_ff[VALUE_W-1]}}, value_min_ff};
         REG_VALUE_MAX:       csr_prdata = {{8{value_max_ff[VALUE_W-1]}}, value_max_ff};
         REG_UPPER_THRESHOLD:
            csr_prdata = {{8{upper_threshold_ff[VALUE_W-1]}}, upper_threshold_ff};
         REG_LOWER_THRESHOLD:
            csr_prdata = {{8{lower_threshold_ff[VALUE_W-1]}}, lower_threshold_ff};
         REG_STEP_SIZE:       csr_prdata = {9'd0, step_size_ff};
         REG_MIN_PERIOD:      csr_prdata = {16'd0, min_period_ff};
         REG_MAX_PERIOD:      csr_prdata = {16'd0, max_period_ff};
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. Each stage loads when it is empty or its
   // successor moves, so bubbles collapse and requests keep flowing while
   // a result waits in the output register.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] s_valid_ff;
   logic [NUM_STAGES:0]   s_ready;
   logic                  rsp_valid_ff;
   logic                  out_load;

   always_comb begin
      s_ready[NUM_STAGES] = !rsp_valid_ff || rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         s_ready[k] = !s_valid_ff[k] || s_ready[k+1];
      end
   end

   assign req_chan.ready = s_ready[0];
   assign out_load       = s_valid_ff[NUM_STAGES-1] && s_ready[NUM_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s_ready[0]) begin
            s_valid_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (s_ready[k]) begin
               s_valid_ff[k] <= s_valid_ff[k-1];
            end
         end
         if (s_ready[NUM_STAGES]) begin
            rsp_valid_ff <= s_valid_ff[NUM_STAGES-1];
         end
      end
   end

   // timestamp and pin level ride along with the scaling stages
   stamp_type  pipe_ts_ff  [NUM_STAGES];
   logic       pipe_bit_ff [NUM_STAGES];
   counts_type s0_counts_ff;

   always_ff @(posedge clock) begin
      if (s_ready[0]) begin
         pipe_ts_ff[0]  <= req_chan.timestamp;
         pipe_bit_ff[0] <= req_chan.raw_bit;
         s0_counts_ff   <= req_chan.raw_counts;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (s_ready[k]) begin
            pipe_ts_ff[k]  <= pipe_ts_ff[k-1];
            pipe_bit_ff[k] <= pipe_bit_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 0 -> 1: clamp counts to the range, multiply by (vmax - vmin).
   // ------------------------------------------------------------------
   logic [CNT_EXT_W-1:0]       cnt_ext;
   logic [CNT_EXT_W-1:0]       cnt_clamped;
   logic [CNT_EXT_W-1:0]       cnt_offset;
   logic signed [VALUE_W:0]    value_span;
   logic signed [PROD_W-1:0]   s1_prod_in;
   logic signed [PROD_W-1:0]   s1_prod_ff;

   always_comb begin
      cnt_ext = CNT_EXT_W'(s0_counts_ff);
      if (cnt_ext < CNT_LO) begin
         cnt_clamped = CNT_LO;
      end else if (cnt_ext > CNT_HI) begin
         cnt_clamped = CNT_HI;
      end else begin
         cnt_clamped = cnt_ext;
      end
      cnt_offset = cnt_clamped - CNT_LO;
      value_span = $signed({value_max_ff[VALUE_W-1], value_max_ff})
                 - $signed({value_min_ff[VALUE_W-1], value_min_ff});
      s1_prod_in = $signed({1'b0, cnt_offset[SPAN_W-1:0]}) * value_span;
   end

   // ------------------------------------------------------------------
   // Stage 1 -> 2: magnitude plus half span (round half away from zero).
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] prod_bits;
   logic [PROD_W-1:0] prod_abs;
   logic [MAG_W-1:0]  s2_mag_in;
   logic [MAG_W-1:0]  s2_mag_ff;
   logic              s2_neg_ff;

   always_comb begin
      prod_bits = s1_prod_ff;
      prod_abs  = prod_bits[PROD_W-1] ? (~prod_bits + PROD_W'(1)) : prod_bits;
      s2_mag_in = prod_abs[MAG_W-1:0] + HALF_SPAN;
   end

   // ------------------------------------------------------------------
   // Stage 2 -> 3: reciprocal multiply as four partial products.
   // ------------------------------------------------------------------
   logic [AL_W+ML_W-1:0] s3_pp_ll_ff;
   logic [AL_W+MH_W-1:0] s3_pp_lh_ff;
   logic [AH_W+ML_W-1:0] s3_pp_hl_ff;
   logic [AH_W+MH_W-1:0] s3_pp_hh_ff;
   logic                 s3_neg_ff;

   // ------------------------------------------------------------------
   // Stage 3 -> 4: sum partial products, shift out the quotient.
   // ------------------------------------------------------------------
   logic [PR_W-1:0]   pp_sum;
   logic [QUOT_W-1:0] s4_quot_ff;
   logic              s4_neg_ff;

   assign pp_sum = PR_W'(s3_pp_ll_ff)
                 + (PR_W'(s3_pp_lh_ff) << ML_W)
                 + (PR_W'(s3_pp_hl_ff) << AL_W)
                 + (PR_W'(s3_pp_hh_ff) << (AL_W + ML_W));

   // ------------------------------------------------------------------
   // Stage 4 -> 5: restore sign, add vmin, saturate to 24 bits.
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0] quot_signed;
   logic signed [SUM_W-1:0] value_sum;
   value_type               s5_scaled_in;
   value_type               s5_scaled_ff;

   always_comb begin
      quot_signed = $signed({1'b0, s4_quot_ff});
      if (s4_neg_ff) begin
         quot_signed = -quot_signed;
      end
      value_sum = $signed({{2{value_min_ff[VALUE_W-1]}}, value_min_ff}) + quot_signed;
      if (!SPAN_OK) begin
         s5_scaled_in = value_min_ff;
      end else if (value_sum > SAT_HI) begin
         s5_scaled_in = SAT_HI[VALUE_W-1:0];
      end else if (value_sum < SAT_LO) begin
         s5_scaled_in = SAT_LO[VALUE_W-1:0];
      end else begin
         s5_scaled_in = value_sum[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready[1]) begin
         s1_prod_ff <= s1_prod_in;
      end
      if (s_ready[2]) begin
         s2_mag_ff <= s2_mag_in;
         s2_neg_ff <= s1_prod_ff[PROD_W-1];
      end
      if (s_ready[3]) begin
         s3_pp_ll_ff <= s2_mag_ff[AL_W-1:0] * RECIP_LO;
         s3_pp_lh_ff <= s2_mag_ff[AL_W-1:0] * RECIP_HI;
         s3_pp_hl_ff <= s2_mag_ff[MAG_W-1:AL_W] * RECIP_LO;
         s3_pp_hh_ff <= s2_mag_ff[MAG_W-1:AL_W] * RECIP_HI;
         s3_neg_ff   <= s2_neg_ff;
      end
      if (s_ready[4]) begin
         s4_quot_ff <= pp_sum[QUOT_SHIFT +: QUOT_W];
         s4_neg_ff  <= s3_neg_ff;
      end
      if (s_ready[5]) begin
         s5_scaled_ff <= s5_scaled_in;
      end
   end

   // ------------------------------------------------------------------
   // Last stage -> output register: sample decision and report filter.
   // All held state is touched only here, so back-to-back requests see
   // the state left by the one before.
   // ------------------------------------------------------------------
   value_type  current_value_ff,  current_value_in;
   logic       current_bit_ff,    current_bit_in;
   value_type  reported_value_ff, reported_value_in;
   logic       reported_bit_ff,   reported_bit_in;
   stamp_type  report_time_ff,    report_time_in;
   stamp_type  sample_time_ff,    sample_time_in;

   logic       rsp_sampled_ff, rsp_report_ff, rsp_bit_ff;
   reason_type rsp_reason_ff,  reason_in;
   value_type  rsp_scaled_ff;

   stamp_type  out_ts;
   stamp_type  sample_age;
   stamp_type  report_age;
   logic       sample_hit;
   logic       report_open;
   logic       mode_analog;
   logic       pin_level;

   // numeric reason terms
   logic signed [VALUE_W:0] value_delta;
   logic [VALUE_W:0]        delta_bits;
   logic [VALUE_W:0]        delta_mag;
   logic                    gt_cross, lt_cross, in_band, step_hit, beat_hit;
   reason_type              numeric_reason;

   always_comb begin
      out_ts      = pipe_ts_ff[NUM_STAGES-1];
      sample_age  = out_ts - sample_time_ff;
      report_age  = out_ts - report_time_ff;
      sample_hit  = sample_age > SAMPLE_INTERVAL;
      report_open = report_age >= 32'(min_period_ff);
      beat_hit    = report_age >= 32'(max_period_ff);
      mode_analog = sensor_mode_ff == MODE_ANALOG;
      pin_level   = pipe_bit_ff[NUM_STAGES-1] ^ sensor_mode_ff[MODE_INVERT_BIT];

      // thresholds equal to the range end switch that crossing off
      gt_cross = (upper_threshold_ff < value_max_ff)
              && ((s5_scaled_ff > upper_threshold_ff)
                  != (reported_value_ff > upper_threshold_ff));
      lt_cross = (lower_threshold_ff > value_min_ff)
              && ((s5_scaled_ff < lower_threshold_ff)
                  != (reported_value_ff < lower_threshold_ff));
      in_band  = (s5_scaled_ff >= upper_threshold_ff)
              && (s5_scaled_ff <= lower_threshold_ff);
      value_delta = $signed({s5_scaled_ff[VALUE_W-1], s5_scaled_ff})
                  - $signed({reported_value_ff[VALUE_W-1], reported_value_ff});
      delta_bits  = value_delta;
      delta_mag   = delta_bits[VALUE_W] ? (~delta_bits + (VALUE_W+1)'(1)) : delta_bits;
      step_hit    = delta_mag >= (VALUE_W+1)'(step_size_ff);

      if (gt_cross) begin
         numeric_reason = REASON_GT;
      end else if (lt_cross) begin
         numeric_reason = REASON_LT;
      end else if (in_band && step_hit) begin
         numeric_reason = REASON_STEP;
      end else if (in_band && beat_hit) begin
         numeric_reason = REASON_HEARTBEAT;
      end else begin
         numeric_reason = REASON_NONE;
      end

      current_value_in  = current_value_ff;
      current_bit_in    = current_bit_ff;
      reported_value_in = reported_value_ff;
      reported_bit_in   = reported_bit_ff;
      report_time_in    = report_time_ff;
      sample_time_in    = sample_time_ff;
      reason_in         = REASON_NONE;

      if (sample_hit) begin
         sample_time_in = out_ts;
         // each mode keeps its own held value
         if (mode_analog) begin
            current_value_in = s5_scaled_ff;
         end else begin
            current_bit_in = pin_level;
         end
         if (report_open) begin
            if (mode_analog) begin
               reason_in = numeric_reason;
            end else if (pin_level != reported_bit_ff) begin
               reason_in = REASON_BIT_CHANGE;
            end else if (beat_hit) begin
               reason_in = REASON_HEARTBEAT;
            end
         end
         if (reason_in != REASON_NONE) begin
            report_time_in = out_ts;
            if (mode_analog) begin
               reported_value_in = s5_scaled_ff;
            end else begin
               reported_bit_in = pin_level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_value_ff  <= '0;
         current_bit_ff    <= 1'b0;
         reported_value_ff <= '0;
         reported_bit_ff   <= 1'b0;
         report_time_ff    <= '0;
         sample_time_ff    <= '0;
      end else if (out_load) begin
         current_value_ff  <= current_value_in;
         current_bit_ff    <= current_bit_in;
         reported_value_ff <= reported_value_in;
         reported_bit_ff   <= reported_bit_in;
         report_time_ff    <= report_time_in;
         sample_time_ff    <= sample_time_in;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s_ready[NUM_STAGES]) begin
         rsp_sampled_ff <= sample_hit;
         rsp_report_ff  <= reason_in != REASON_NONE;
         rsp_reason_ff  <= reason_in;
         rsp_scaled_ff  <= current_value_in;
         rsp_bit_ff     <= current_bit_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sampled      = rsp_sampled_ff;
   assign rsp_chan.report       = rsp_report_ff;
   assign rsp_chan.reason       = rsp_reason_ff;
   assign rsp_chan.scaled_value = rsp_scaled_ff;
   assign rsp_chan.bit_value    = rsp_bit_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `SSRF_ASSERT_IMP(a_no_report_without_sample, clock, reset, rsp_chan.valid && !rsp_chan.sampled, !rsp_chan.report && (rsp_chan.reason == REASON_NONE), "report on a request that took no sample")
   `SSRF_ASSERT_NXT(a_report_sets_time, clock, reset, out_load && (reason_in != REASON_NONE), report_time_ff == $past(out_ts), "report time not updated on report")
   `SSRF_ASSERT_NXT(a_sample_time_held, clock, reset, out_load && !sample_hit, $stable(sample_time_ff), "sample time moved without a sample")

endmodule

FILE: test/sample_report_checker.sv
`timescale 1ns / 100ps

module sample_report_checker
   import ssrf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ssrf_req_if                   req_mon,
   ssrf_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  end_of_test,
   output int                    reports_due,
   output int                    fault_count
);

   typedef struct packed {
      logic       sampled;
      logic       report;
      reason_type reason;
      value_type  scaled_value;
      logic       bit_value;
   } filter_result;

   // register copy
   mode_type   cfg_mode;
   value_type  cfg_vmin, cfg_vmax, cfg_gt, cfg_lt;
   step_type   cfg_step;
   period_type cfg_pmin, cfg_pmax;

   // filter state
   value_type  held_value, told_value;
   logic       held_bit, told_bit;
   stamp_type  told_time, last_sample;

   filter_result expected_results[$];
   bit           leftovers_flagged;

   task automatic note_fault(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fault_count++;
   endtask

   // linear map of clamped counts, rounded half away from zero
   function automatic value_type scale_reading(input counts_type counts);
      longint lo, hi, c, span, num, q;
      lo   = COUNT_LOW_DEF;
      hi   = COUNT_HIGH_DEF;
      span = hi - lo;
      if (span <= 0) begin
         return cfg_vmin;
      end
      c = longint'(counts);
      if (c < lo) c = lo;
      if (c > hi) c = hi;
      c   = c - lo;
      num = c * (longint'(cfg_vmax) - longint'(cfg_vmin));
      if (num >= 0) q = (num + span / 2) / span;
      else q = -((-num + span / 2) / span);
      q = q + longint'(cfg_vmin);
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return value_type'(q);
   endfunction

   function automatic reason_type analog_reason(input stamp_type elapsed);
      int   v, last, gt, lt, diff, stp;
      logic in_band;
      v       = held_value;
      last    = told_value;
      gt      = cfg_gt;
      lt      = cfg_lt;
      stp     = int'(cfg_step);
      diff    = v - last;
      in_band = (v >= gt) && (v <= lt);
      if (gt < int'(cfg_vmax) && ((v > gt) != (last > gt))) return REASON_GT;
      if (lt > int'(cfg_vmin) && ((v < lt) != (last < lt))) return REASON_LT;
      if (in_band && (diff >= stp || -diff >= stp)) return REASON_STEP;
      if (in_band && elapsed >= stamp_type'(cfg_pmax)) return REASON_HEARTBEAT;
      return REASON_NONE;
   endfunction

   function automatic filter_result filter_step(input stamp_type ts, input counts_type counts,
                                                input logic pin);
      filter_result res;
      stamp_type    elapsed;
      reason_type   why;
      why         = REASON_NONE;
      res.sampled = 1'b0;
      if (stamp_type'(ts - last_sample) > SAMPLE_INTERVAL) begin
         res.sampled = 1'b1;
         last_sample = ts;
         if (cfg_mode == MODE_ANALOG) held_value = scale_reading(counts);
         else held_bit = pin ^ cfg_mode[MODE_INVERT_BIT];
         elapsed = ts - told_time;
         if (elapsed >= stamp_type'(cfg_pmin)) begin
            if (cfg_mode == MODE_ANALOG) begin
               why = analog_reason(elapsed);
               if (why != REASON_NONE) told_value = held_value;
            end else if (held_bit != told_bit) begin
               why      = REASON_BIT_CHANGE;
               told_bit = held_bit;
            end else if (elapsed >= stamp_type'(cfg_pmax)) begin
               why = REASON_HEARTBEAT;
            end
         end
         if (why != REASON_NONE) told_time = ts;
      end
      res.report       = (why != REASON_NONE);
      res.reason       = why;
      res.scaled_value = held_value;
      res.bit_value    = held_bit;
      return res;
   endfunction

   task automatic check_result(input filter_result want);
      if (rsp_mon.sampled !== want.sampled)
         note_fault($sformatf("sampled %b, want %b", rsp_mon.sampled, want.sampled));
      if (rsp_mon.report !== want.report)
         note_fault($sformatf("report %b, want %b", rsp_mon.report, want.report));
      if (rsp_mon.reason !== want.reason)
         note_fault($sformatf("reason %0d, want %0d", rsp_mon.reason, want.reason));
      if (rsp_mon.scaled_value !== want.scaled_value)
         note_fault($sformatf("scaled_value %0d, want %0d",
                              rsp_mon.scaled_value, want.scaled_value));
      if (rsp_mon.bit_value !== want.bit_value)
         note_fault($sformatf("bit_value %b, want %b", rsp_mon.bit_value, want.bit_value));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mode    = SENSOR_MODE_RST;
         cfg_vmin    = VALUE_MIN_RST;
         cfg_vmax    = VALUE_MAX_RST;
         cfg_gt      = UPPER_THRESHOLD_RST;
         cfg_lt      = LOWER_THRESHOLD_RST;
         cfg_step    = STEP_SIZE_RST;
         cfg_pmin    = MIN_PERIOD_RST;
         cfg_pmax    = MAX_PERIOD_RST;
         held_value  = '0;
         told_value  = '0;
         held_bit    = 1'b0;
         told_bit    = 1'b0;
         told_time   = '0;
         last_sample = '0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_SENSOR_MODE:     cfg_mode = csr_pwdata[1:0];
               REG_VALUE_MIN:       cfg_vmin = value_type'(csr_pwdata[23:0]);
               REG_VALUE_MAX:       cfg_vmax = value_type'(csr_pwdata[23:0]);
               REG_UPPER_THRESHOLD: cfg_gt   = value_type'(csr_pwdata[23:0]);
               REG_LOWER_THRESHOLD: cfg_lt   = value_type'(csr_pwdata[23:0]);
               REG_STEP_SIZE:       cfg_step = csr_pwdata[22:0];
               REG_MIN_PERIOD:      cfg_pmin = csr_pwdata[15:0];
               REG_MAX_PERIOD:      cfg_pmax = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) note_fault("result with no request outstanding");
            else check_result(expected_results.pop_front());
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(filter_step(req_mon.timestamp, req_mon.raw_counts,
                                                   req_mon.raw_bit));
         if (end_of_test && !leftovers_flagged && expected_results.size() != 0) begin
            note_fault($sformatf("%0d results never arrived", expected_results.size()));
            leftovers_flagged = 1'b1;
         end
      end
      reports_due <= expected_results.size();
   end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ssrf_pkg::*;

   // digital mode codes; only analog has a name in the package
   localparam mode_type MODE_DIGITAL         = 2'd1;
   localparam mode_type MODE_DIGITAL_INV     = 2'd2;
   localparam mode_type MODE_DIGITAL_INV_ALT = 2'd3;

   localparam int VALUE_LOWEST  = -8388608;
   localparam int VALUE_HIGHEST = 8388607;
   localparam int STEP_HIGHEST  = 8388607;
   localparam int PERIOD_MAX    = 65535;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   // pipeline is 6 deep; give it a comfortable margin after the last result
   localparam int DRAIN_CYCLES    = 20;
   // worst quiet stretch is one full gap plus latency plus one full stall
   localparam int QUIET_LIMIT     = 2000;

   logic clock = 1'b0;
   logic reset;

   ssrf_req_if req_chan ();
   ssrf_rsp_if rsp_chan ();

   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic end_of_test;
   int   reports_due;
   int   fault_count;

   // per-phase idle bounds: 0 gives back-to-back traffic, 15 the full spread
   int   gap_max;
   int   stall_max;
   int   quiet_cycles;

   always #5 clock = ~clock;

   sensor_sample_report_filter_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sample_report_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .end_of_test (end_of_test),
      .reports_due (reports_due),
      .fault_count (fault_count)
   );

   // Watchdog: any handshake or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result side: stall a random number of cycles before each result.
   initial begin : result_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = $urandom_range(stall_max, 0);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   function automatic int pick_between(input int a, input int b);
      int lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   // One request, after a random gap. valid stays high when the next
   // request follows with no gap.
   task automatic send_reading(input stamp_type ts, input counts_type counts, input logic pin);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.timestamp  <= ts;
      req_chan.raw_counts <= counts;
      req_chan.raw_bit    <= pin;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop sending and wait until every request has its result back;
   // each request gives exactly one result, so the block is idle then.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (reports_due != 0);
   endtask

   // Setup cycle, then access cycle; the write lands when pready is seen.
   // psel is left high so back-to-back writes need no extra cycle.
   task automatic write_reg(input reg_index_type idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic close_csr();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_settings(input mode_type mode, input int vmin, input int vmax,
                                 input int gt, input int lt, input int step,
                                 input int pmin, input int pmax);
      wait_drained();
      write_reg(REG_SENSOR_MODE, 32'(mode));
      write_reg(REG_VALUE_MIN, 32'(vmin));
      write_reg(REG_VALUE_MAX, 32'(vmax));
      write_reg(REG_UPPER_THRESHOLD, 32'(gt));
      write_reg(REG_LOWER_THRESHOLD, 32'(lt));
      write_reg(REG_STEP_SIZE, 32'(step));
      write_reg(REG_MIN_PERIOD, 32'(pmin));
      write_reg(REG_MAX_PERIOD, 32'(pmax));
      close_csr();
   endtask

   initial begin : stimulus
      stamp_type ts;
      int        counts_now;
      logic      bit_now;
      mode_type  mode;
      int        r, phase, n, span;
      int        vmin, vmax, gt, lt, step, pmin, pmax;

      reset               <= 1'b1;
      end_of_test         <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.timestamp  <= '0;
      req_chan.raw_counts <= '0;
      req_chan.raw_bit    <= 1'b0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      gap_max              = 3;
      stall_max            = 3;
      quiet_cycles         = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, reset settings: analog, 0..100.0, band 40..60 ----
      send_reading(32'd0, 10'd0, 1'b0);      // no time passed: no sample
      send_reading(32'd1, 10'd1023, 1'b1);   // one second is not enough either
      send_reading(32'd2, 10'd1023, 1'b0);   // top of scale, crosses upper
      send_reading(32'd4, 10'd0, 1'b1);      // bottom of scale, back across upper
      send_reading(32'd6, 10'd700, 1'b0);    // jumps over the whole band
      send_reading(32'd8, 10'd450, 1'b0);    // drops into the band: lower crossing
      send_reading(32'd10, 10'd460, 1'b0);   // in band, change under one step
      send_reading(32'd12, 10'd470, 1'b0);   // in band, a full step from last report
      send_reading(32'd14, 10'd470, 1'b0);   // steady, heartbeat not yet due
      send_reading(32'd18, 10'd470, 1'b0);   // steady past max period: heartbeat
      send_reading(32'd19, 10'd470, 1'b0);   // too soon for a sample

      // min period holds back a crossing until it has run out
      wait_drained();
      write_reg(REG_MIN_PERIOD, 32'd10);
      close_csr();
      send_reading(32'd21, 10'd1023, 1'b0);
      send_reading(32'd30, 10'd1023, 1'b0);

      // digital modes: bit change, heartbeat with zero periods, both inversions
      wait_drained();
      write_reg(REG_SENSOR_MODE, 32'(MODE_DIGITAL));
      close_csr();
      send_reading(32'd32, 10'd0, 1'b1);
      send_reading(32'd34, 10'd0, 1'b1);
      wait_drained();
      write_reg(REG_MIN_PERIOD, 32'd0);
      write_reg(REG_MAX_PERIOD, 32'd0);
      close_csr();
      send_reading(32'd36, 10'd0, 1'b1);
      wait_drained();
      write_reg(REG_SENSOR_MODE, 32'(MODE_DIGITAL_INV));
      close_csr();
      send_reading(32'd38, 10'd0, 1'b1);
      wait_drained();
      write_reg(REG_SENSOR_MODE, 32'(MODE_DIGITAL_INV_ALT));
      close_csr();
      send_reading(32'd40, 10'd0, 1'b0);

      // timestamp wrap: the difference is taken modulo 2^32
      send_reading(32'hFFFF_FFFE, 10'd1023, 1'b1);
      send_reading(32'hFFFF_FFFF, 10'd1023, 1'b0);
      send_reading(32'd0, 10'd0, 1'b0);

      // ---- random part: a fresh setting per phase ----
      ts         = 32'd0;
      counts_now = 512;
      bit_now    = 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               // full-scale range, heartbeat practically off
               mode = MODE_ANALOG;
               vmin = VALUE_LOWEST;
               vmax = VALUE_HIGHEST;
               gt   = pick_between(vmin, vmax);
               lt   = pick_between(vmin, vmax);
               step = $urandom_range(65535, 0);
               pmin = 0;
               pmax = PERIOD_MAX;
            end
            1: begin
               // inverted range, both crossings disabled, largest step and min period
               mode = MODE_ANALOG;
               vmin = VALUE_HIGHEST;
               vmax = VALUE_LOWEST;
               gt   = vmax;
               lt   = vmin;
               step = STEP_HIGHEST;
               pmin = PERIOD_MAX;
               pmax = 0;
            end
            default: begin
               mode = ($urandom_range(4, 0) < 3) ? MODE_ANALOG
                                                 : mode_type'($urandom_range(3, 1));
               if ($urandom_range(1, 0) != 0) begin
                  vmin = pick_between(-40000, 40000);
                  vmax = pick_between(-40000, 40000);
               end else begin
                  vmin = $signed($urandom) >>> 8;
                  vmax = $signed($urandom) >>> 8;
               end
               // thresholds mostly inside the range so crossings happen
               gt   = ($urandom_range(5, 0) == 0) ? vmax : pick_between(vmin, vmax);
               lt   = ($urandom_range(5, 0) == 0) ? vmin : pick_between(vmin, vmax);
               span = (vmax > vmin) ? vmax - vmin : vmin - vmax;
               step = ($urandom_range(5, 0) == 0) ? 0 : $urandom_range(span / 8, 0);
               pmin = $urandom_range(3, 0);
               pmax = $urandom_range(12, 0);
            end
         endcase
         write_settings(mode, vmin, vmax, gt, lt, step, pmin, pmax);
         gap_max   = ($urandom_range(2, 0) == 0) ? 0 : 15;
         stall_max = ($urandom_range(2, 0) == 0) ? 0 : 15;

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // mostly small time steps so sampling and the periods all matter;
            // rare large jumps exercise the upper timestamp bits and wrap
            r = $urandom_range(99, 0);
            if (r < 3) ts = ts + $urandom;
            else if (r < 10) ts = ts + $urandom_range(80000, 2);
            else ts = ts + $urandom_range(4, 0);
            // counts drift slowly so the band and step rules get exercised
            r = $urandom_range(99, 0);
            if (r < 25) begin
               counts_now = $urandom_range(1023, 0);
            end else if (r < 30) begin
               counts_now = ($urandom_range(1, 0) != 0) ? 1023 : 0;
            end else begin
               counts_now = counts_now + int'($urandom_range(40, 0)) - 20;
               if (counts_now < 0) counts_now = 0;
               if (counts_now > 1023) counts_now = 1023;
            end
            if ($urandom_range(3, 0) == 0) bit_now = $urandom_range(1, 0);
            send_reading(ts, counts_type'(counts_now), bit_now);
         end
      end

      // ---- wind down ----
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(posedge clock);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/ssrf_pkg.sv
sv/ssrf_req_if.sv
sv/ssrf_rsp_if.sv
sv/sensor_sample_report_filter_unit.sv
test/sample_report_checker.sv
test/testbench.sv
